[rtl/core/d8fd_pkg.sv]
// Shared types, constants and the candidate-select function for the D8 flow unit.
// No dependencies; every module of the block imports this package.
package d8fd_pkg;

   localparam int HEIGHT_W    = 16;
   localparam int NUM_DIRS    = 8;
   localparam int DIR_W       = 3;
   localparam int DIAG_WEIGHT = 46334;
   localparam int WEIGHT_W    = 17;
   localparam int ORTHO_SHIFT = 16;
   // difference is HEIGHT_W+1 bits signed, scaled by a WEIGHT_W-bit weight
   localparam int SLOPE_W     = HEIGHT_W + 1 + WEIGHT_W;

   typedef struct packed {
      logic [HEIGHT_W-1:0] center_height;
      logic                center_is_ocean;
      logic [HEIGHT_W-1:0] north_height;
      logic [HEIGHT_W-1:0] northeast_height;
      logic [HEIGHT_W-1:0] east_height;
      logic [HEIGHT_W-1:0] southeast_height;
      logic [HEIGHT_W-1:0] south_height;
      logic [HEIGHT_W-1:0] southwest_height;
      logic [HEIGHT_W-1:0] west_height;
      logic [HEIGHT_W-1:0] northwest_height;
      logic [NUM_DIRS-1:0] neighbor_ocean_mask;
      logic [NUM_DIRS-1:0] neighbor_inside_mask;
   } req_type;

   typedef struct packed {
      logic [DIR_W-1:0] flow_direction;
      logic             has_flow;
   } rsp_type;

   // one lane's registered finding
   typedef struct packed {
      logic [SLOPE_W-1:0] slope;
      logic               in_grid;
      logic               ocean;
   } lane_type;

   // one entry of the merge tree
   typedef struct packed {
      logic               found;
      logic [DIR_W-1:0]   dir;
      logic [SLOPE_W-1:0] slope;
   } cand_type;

   // Keep left unless right is found and left is not found or is less steep.
   function automatic cand_type pick(input cand_type left, input cand_type right);
      cand_type res;
      res = left;
      if (right.found && (!left.found || ($signed(right.slope) > $signed(left.slope)))) begin
         res = right;
      end
      return res;
   endfunction

endpackage

[rtl/core/d8fd_lane.sv]
// One slope lane of the D8 flow unit: weighted height drop to one neighbor.
// Depends on d8fd_pkg.
module d8fd_lane
   import d8fd_pkg::*;
#(
   parameter bit IS_DIAG = 1'b0
) (
   input  logic                clock,
   input  logic                en,
   input  logic [HEIGHT_W-1:0] center,
   input  logic [HEIGHT_W-1:0] neighbor,
   input  logic                in_grid,
   input  logic                ocean,
   output lane_type            lane_out
);

   localparam int EXT_W   = SLOPE_W - HEIGHT_W - 1;
   localparam int ORTHO_X = SLOPE_W - HEIGHT_W - 1 - ORTHO_SHIFT;

   logic signed [HEIGHT_W:0] diff;
   logic [SLOPE_W-1:0]       slope;
   lane_type                 lane_in;
   lane_type                 lane_ff;

   assign diff = $signed({1'b0, center}) - $signed({1'b0, neighbor});

   // two's complement product, exact in SLOPE_W bits
   if (IS_DIAG) begin : g_diag
      assign slope = {{EXT_W{diff[HEIGHT_W]}}, diff} * SLOPE_W'(DIAG_WEIGHT);
   end else begin : g_ortho
      assign slope = {{ORTHO_X{diff[HEIGHT_W]}}, diff, {ORTHO_SHIFT{1'b0}}};
   end

   always_comb begin
      lane_in.slope   = slope;
      lane_in.in_grid = in_grid;
      lane_in.ocean   = ocean;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

[rtl/core/d8fd_merge.sv]
// Merge stage of the D8 flow unit: picks the winning lane through a registered tree.
// Depends on d8fd_pkg.
module d8fd_merge
   import d8fd_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  lane_type lanes [NUM_DIRS],
   output rsp_type  result
);

   logic [NUM_DIRS-1:0] ocean_hit;
   logic [NUM_DIRS-1:0] later_ocean;
   logic                any_ocean;
   cand_type            leaf [NUM_DIRS];
   cand_type            lvl1 [NUM_DIRS/2];
   cand_type            lvl2_in [NUM_DIRS/4];
   cand_type            lvl2_ff [NUM_DIRS/4];
   cand_type            root;

   // The last ocean neighbor always wins over anything before it, so drop
   // every lane ahead of it; without ocean, only strictly downhill lanes count.
   always_comb begin
      for (int d = 0; d < NUM_DIRS; d++) begin
         ocean_hit[d] = lanes[d].in_grid & lanes[d].ocean;
      end
      any_ocean = |ocean_hit;
      for (int d = 0; d < NUM_DIRS; d++) begin
         later_ocean[d] = |(ocean_hit >> (d + 1));
      end
      for (int d = 0; d < NUM_DIRS; d++) begin
         leaf[d].found = lanes[d].in_grid && !later_ocean[d] &&
                         (any_ocean || (!lanes[d].slope[SLOPE_W-1] && (|lanes[d].slope)));
         leaf[d].dir   = DIR_W'(d);
         leaf[d].slope = lanes[d].slope;
      end
      for (int i = 0; i < NUM_DIRS/2; i++) begin
         lvl1[i] = pick(leaf[2*i], leaf[2*i+1]);
      end
      for (int i = 0; i < NUM_DIRS/4; i++) begin
         lvl2_in[i] = pick(lvl1[2*i], lvl1[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lvl2_ff <= lvl2_in;
      end
   end

   always_comb begin
      root                  = pick(lvl2_ff[0], lvl2_ff[1]);
      result.has_flow       = root.found;
      result.flow_direction = root.found ? root.dir : '0;
   end

endmodule

[rtl/core/d8_flow_direction_unit.sv]
// Top level of the D8 flow unit: eight slope lanes, the merge tree and the output register.
// Depends on d8fd_pkg, d8fd_lane and d8fd_merge.
//
// D8 steepest-descent flow direction for one grid cell per transfer. A request
// carries the cell's height, its ocean flag and the eight neighbor heights with
// their ocean and inside-grid masks; the response gives the chosen direction
// (0 = north, clockwise to 7 = northwest) and a has_flow flag, which is low for
// an ocean cell or a sink. The unit takes one request every clock cycle while
// req_stall is low. The first stage computes the eight weighted slopes in
// parallel (one constant multiply per diagonal lane) into the lane registers,
// the second runs the first two levels of the select tree, the third the last
// level into the output register. Responses come out in request order. While
// the response side stalls, requests are still taken until the three pipeline
// registers are full; empty stages close up behind a stalled response.
module d8_flow_direction_unit
   import d8fd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [HEIGHT_W-1:0] nb_height [NUM_DIRS];
   lane_type            lanes [NUM_DIRS];
   rsp_type             merge_result;

   logic    valid_a_ff, valid_a_in;
   logic    valid_b_ff, valid_b_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    en_a, en_b, en_c;

   // Stage enables: a stage advances when it is empty or the stage after it advances.
   assign en_c = !rsp_valid_ff || !rsp_stall;
   assign en_b = !valid_b_ff || en_c;
   assign en_a = !valid_a_ff || en_b;

   assign req_stall = !en_a;

   // Neighbor heights in direction order N, NE, E, SE, S, SW, W, NW.
   assign nb_height[0] = req_data.north_height;
   assign nb_height[1] = req_data.northeast_height;
   assign nb_height[2] = req_data.east_height;
   assign nb_height[3] = req_data.southeast_height;
   assign nb_height[4] = req_data.south_height;
   assign nb_height[5] = req_data.southwest_height;
   assign nb_height[6] = req_data.west_height;
   assign nb_height[7] = req_data.northwest_height;

   // One lane per direction; odd directions are diagonals.
   // An ocean center masks every neighbor, so nothing can win.
   for (genvar d = 0; d < NUM_DIRS; d++) begin : g_lane
      d8fd_lane #(
         .IS_DIAG ((d % 2) == 1)
      ) u_lane (
         .clock    (clock),
         .en       (en_a),
         .center   (req_data.center_height),
         .neighbor (nb_height[d]),
         .in_grid  (req_data.neighbor_inside_mask[d] & !req_data.center_is_ocean),
         .ocean    (req_data.neighbor_ocean_mask[d]),
         .lane_out (lanes[d])
      );
   end

   d8fd_merge u_merge (
      .clock  (clock),
      .en     (en_b),
      .lanes  (lanes),
      .result (merge_result)
   );

   // Advance the valid bits with their stages; hold them while stalled.
   always_comb begin
      valid_a_in   = en_a ? req_valid  : valid_a_ff;
      valid_b_in   = en_b ? valid_a_ff : valid_b_ff;
      rsp_valid_in = en_c ? valid_b_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_a_ff   <= valid_a_in;
         valid_b_ff   <= valid_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register: load the merged result when the response side can move.
   always_ff @(posedge clock) begin
      if (en_c) begin
         rsp_data_ff <= merge_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An empty first stage never pushes back on requests.
   a_empty_accepts : assert property (@(posedge clock) disable iff (reset)
      !valid_a_ff |-> !req_stall)
      else $error("request stalled with an empty first stage");

   // A stalled response must not drop the item waiting behind it.
   a_hold_stage_b : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && valid_b_ff) |=> valid_b_ff)
      else $error("merge stage item lost under response stall");

   // A transfer without flow always reports direction zero.
   a_no_flow_dir : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.has_flow) |-> (rsp_data.flow_direction == '0))
      else $error("direction set on a response without flow");

endmodule
